// File: src/sdspi_pkg.sv
`default_nettype none
package sdspi_pkg;
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_PRE   = 3'd1;
  localparam logic [2:0] PH_GAP   = 3'd2;
  localparam logic [2:0] PH_FRAME = 3'd3;
  localparam logic [2:0] PH_POLL  = 3'd4;
  localparam logic [2:0] PH_OCR   = 3'd5;
  localparam logic [2:0] PH_BUSY  = 3'd6;
  localparam logic [2:0] PH_TRAIL = 3'd7;

  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_CMD0  = 3'd1;
  localparam logic [2:0] ST_CMD8  = 3'd2;
  localparam logic [2:0] ST_CMD55 = 3'd3;
  localparam logic [2:0] ST_CMD41 = 3'd4;
  localparam logic [2:0] ST_CMD58 = 3'd5;
  localparam logic [2:0] ST_CMD59 = 3'd6;
  localparam logic [2:0] ST_CMD16 = 3'd7;

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_CMD  = 2'd1;
  localparam logic [1:0] MODE_RX   = 2'd2;

  localparam logic [1:0] REG_IDLE_RETRY = 2'd0;
  localparam logic [1:0] REG_INIT_RETRY = 2'd1;
  localparam logic [1:0] REG_POLL_LIMIT = 2'd2;

  localparam logic [31:0] ARG_CMD8  = 32'h0000_01AA;
  localparam logic [31:0] ARG_CMD41 = 32'h4000_0000;
  localparam logic [31:0] ARG_CMD16 = 32'd512;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       chip_select;
    logic [7:0] resp_byte;
    logic       done_res;
    logic [1:0] init_status;
    logic [1:0] card_type;
    logic       high_capacity;
  } result_t;
endpackage
`default_nettype wire

// File: src/sd_card_spi_init_and_command_core.sv
// the result of an accepted request is registered in the output register
// throughput: one request per cycle while the output register is free or being taken; state updates on acceptance
// the output register frees itself when its result is taken, and can take a new result in the same edge
// reset: synchronous active low, controller idle, limits 32 / 254 / 255
`default_nettype none
module sd_card_spi_init_and_command_core #(
  parameter int PREAMBLE_BYTES = 10
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [7:0]  cfg_data,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [1:0]  in_mode,
  input  wire [5:0]  in_cmd_index,
  input  wire [31:0] in_cmd_arg,
  input  wire [7:0]  in_rx_byte,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_valid,
  output logic       out_chip_select,
  output logic [7:0] out_resp_byte,
  output logic       out_done_res,
  output logic [1:0] out_init_status,
  output logic [1:0] out_card_type,
  output logic       out_high_capacity
);
  import sdspi_pkg::*;

  localparam logic [3:0] PRE_LAST = 4'(PREAMBLE_BYTES - 1);

  logic [7:0] idle_lim_r, init_lim_r, poll_lim_r;
  logic [2:0] phase_r, phase_nxt, stage_r, stage_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] retry_r, retry_nxt, poll_r, poll_nxt;
  logic [5:0] cmd_r, cmd_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic ba_r, ba_nxt, v2_r, v2_nxt;
  logic [1:0] kind_r, kind_nxt, ires_r, ires_nxt;
  logic [7:0] last_r, last_nxt;
  result_t res_r, res_nxt;
  logic out_valid_r;
  logic acc;

  // command start request
  logic       sc_en;
  logic [5:0] sc_cmd;
  logic [31:0] sc_arg;
  logic [7:0] frame_b;
  logic       finish;
  logic [7:0] tx;
  logic       txv, cs;

  assign in_ready = !out_valid_r || out_ready;
  assign acc = in_valid && in_ready;
  assign out_valid = out_valid_r;

  function automatic logic [7:0] frame_of(input logic [3:0] c, input logic [5:0] cm,
                                          input logic [31:0] a);
    case (c)
      4'd0: frame_of = {2'b01, cm};
      4'd1: frame_of = a[31:24];
      4'd2: frame_of = a[23:16];
      4'd3: frame_of = a[15:8];
      4'd4: frame_of = a[7:0];
      default: frame_of = (cm == 6'd8) ? 8'h87 : 8'h95;
    endcase
  endfunction

  always_comb begin
    phase_nxt = phase_r; stage_nxt = stage_r; cnt_nxt = cnt_r;
    retry_nxt = retry_r; poll_nxt = poll_r; cmd_nxt = cmd_r; arg_nxt = arg_r;
    ba_nxt = ba_r; v2_nxt = v2_r; kind_nxt = kind_r; ires_nxt = ires_r;
    last_nxt = last_r;
    sc_en = 1'b0; sc_cmd = '0; sc_arg = '0; finish = 1'b0;
    tx = 8'h00; txv = 1'b0; cs = 1'b0;
    frame_b = '0;
    case (in_mode)
      MODE_INIT: begin
        stage_nxt = ST_CMD0; phase_nxt = PH_PRE; cnt_nxt = '0;
        tx = 8'hFF; txv = 1'b1;
      end
      MODE_CMD: begin
        stage_nxt = ST_NONE; sc_en = 1'b1; sc_cmd = in_cmd_index; sc_arg = in_cmd_arg;
      end
      MODE_RX: begin
        unique case (phase_r)
          PH_PRE: begin
            if (cnt_r < PRE_LAST) begin
              cnt_nxt = cnt_r + 4'd1; tx = 8'hFF; txv = 1'b1;
            end else begin
              retry_nxt = '0; stage_nxt = ST_CMD0; sc_en = 1'b1;
            end
          end
          PH_GAP: begin
            if (cnt_r < 4'd1) begin
              cnt_nxt = cnt_r + 4'd1; tx = 8'hFF; txv = 1'b1;
            end else begin
              retry_nxt = '0; v2_nxt = 1'b1; stage_nxt = ST_CMD8;
              sc_en = 1'b1; sc_cmd = 6'd8; sc_arg = ARG_CMD8;
            end
          end
          PH_FRAME: begin
            if (cnt_r < 4'd5) begin
              cnt_nxt = cnt_r + 4'd1;
              tx = frame_of(cnt_nxt, cmd_r, arg_r); txv = 1'b1; cs = 1'b1;
            end else begin
              phase_nxt = PH_POLL; poll_nxt = '0; tx = 8'hFF; txv = 1'b1; cs = 1'b1;
            end
          end
          PH_POLL: begin
            tx = 8'hFF; txv = 1'b1; cs = 1'b1;
            if (in_rx_byte == 8'hFF && poll_r < poll_lim_r) begin
              poll_nxt = poll_r + 8'd1;
            end else begin
              last_nxt = in_rx_byte;
              if (cmd_r == 6'd58 && in_rx_byte == 8'h00) begin
                phase_nxt = PH_OCR; cnt_nxt = '0;
              end else if (cmd_r == 6'd38) begin
                phase_nxt = PH_BUSY;
              end else begin
                phase_nxt = PH_TRAIL;
              end
            end
          end
          PH_OCR: begin
            if (cnt_r == 4'd0) ba_nxt = in_rx_byte[6];
            if (cnt_r < 4'd3) cnt_nxt = cnt_r + 4'd1;
            else phase_nxt = PH_TRAIL;
            tx = 8'hFF; txv = 1'b1; cs = 1'b1;
          end
          PH_BUSY: begin
            if (in_rx_byte != 8'h00) phase_nxt = PH_TRAIL;
            tx = 8'hFF; txv = 1'b1; cs = 1'b1;
          end
          PH_TRAIL: begin
            unique case (stage_r)
              ST_CMD0: begin
                if (retry_r >= idle_lim_r) begin
                  ires_nxt = 2'd1; finish = 1'b1;
                end else begin
                  retry_nxt = retry_r + 8'd1;
                  if (last_r == 8'h01) begin
                    phase_nxt = PH_GAP; cnt_nxt = '0; tx = 8'hFF; txv = 1'b1;
                  end else sc_en = 1'b1;
                end
              end
              ST_CMD8: begin
                if (retry_r >= init_lim_r) begin
                  v2_nxt = 1'b0; kind_nxt = 2'd1; retry_nxt = '0;
                  stage_nxt = ST_CMD55; sc_en = 1'b1; sc_cmd = 6'd55;
                end else begin
                  retry_nxt = retry_r + 8'd1;
                  if (last_r == 8'h01) begin
                    retry_nxt = '0; stage_nxt = ST_CMD55; sc_en = 1'b1; sc_cmd = 6'd55;
                  end else begin
                    sc_en = 1'b1; sc_cmd = 6'd8; sc_arg = ARG_CMD8;
                  end
                end
              end
              ST_CMD55: begin
                stage_nxt = ST_CMD41; sc_en = 1'b1; sc_cmd = 6'd41; sc_arg = ARG_CMD41;
              end
              ST_CMD41: begin
                if (retry_r >= init_lim_r) begin
                  ires_nxt = 2'd2; finish = 1'b1;
                end else if (last_r != 8'h00) begin
                  retry_nxt = retry_r + 8'd1;
                  stage_nxt = ST_CMD55; sc_en = 1'b1; sc_cmd = 6'd55;
                end else begin
                  ba_nxt = 1'b0; retry_nxt = '0; sc_en = 1'b1;
                  if (v2_r) begin
                    stage_nxt = ST_CMD58; sc_cmd = 6'd58;
                  end else begin
                    stage_nxt = ST_CMD59; sc_cmd = 6'd59;
                  end
                end
              end
              ST_CMD58: begin
                sc_en = 1'b1;
                if (retry_r >= init_lim_r) begin
                  kind_nxt = 2'd0; stage_nxt = ST_CMD59; sc_cmd = 6'd59;
                end else begin
                  retry_nxt = retry_r + 8'd1;
                  if (last_r == 8'h00) begin
                    kind_nxt = ba_r ? 2'd2 : 2'd3; stage_nxt = ST_CMD59; sc_cmd = 6'd59;
                  end else sc_cmd = 6'd58;
                end
              end
              ST_CMD59: begin
                stage_nxt = ST_CMD16; sc_en = 1'b1; sc_cmd = 6'd16; sc_arg = ARG_CMD16;
              end
              ST_CMD16: begin
                ires_nxt = 2'd0; finish = 1'b1;
              end
              default: finish = 1'b1;
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (finish) begin
      phase_nxt = PH_IDLE; stage_nxt = ST_NONE;
    end
    if (sc_en) begin
      cmd_nxt = sc_cmd;
      arg_nxt = sc_arg;
      if (!ba_nxt && (sc_cmd == 6'd17 || sc_cmd == 6'd18 || sc_cmd == 6'd24 ||
                      sc_cmd == 6'd25 || sc_cmd == 6'd32 || sc_cmd == 6'd33))
        arg_nxt = {sc_arg[22:0], 9'd0};
      phase_nxt = PH_FRAME; cnt_nxt = '0;
      frame_b = frame_of(4'd0, sc_cmd, arg_nxt);
      tx = frame_b; txv = 1'b1; cs = 1'b1;
    end
    res_nxt.tx_byte = tx;
    res_nxt.tx_valid = txv;
    res_nxt.chip_select = cs;
    res_nxt.resp_byte = last_nxt;
    res_nxt.done_res = finish;
    res_nxt.init_status = ires_nxt;
    res_nxt.card_type = kind_nxt;
    res_nxt.high_capacity = ba_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_lim_r <= 8'd32; init_lim_r <= 8'd254; poll_lim_r <= 8'd255;
      phase_r <= PH_IDLE; stage_r <= ST_NONE; cnt_r <= '0; retry_r <= '0;
      poll_r <= '0; cmd_r <= '0; arg_r <= '0; ba_r <= 1'b0; v2_r <= 1'b0;
      kind_r <= '0; ires_r <= '0; last_r <= 8'hFF; out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IDLE_RETRY: idle_lim_r <= cfg_data;
          REG_INIT_RETRY: init_lim_r <= cfg_data;
          REG_POLL_LIMIT: poll_lim_r <= cfg_data;
          default: ;
        endcase
      end
      if (acc) begin
        phase_r <= phase_nxt; stage_r <= stage_nxt; cnt_r <= cnt_nxt;
        retry_r <= retry_nxt; poll_r <= poll_nxt; cmd_r <= cmd_nxt; arg_r <= arg_nxt;
        ba_r <= ba_nxt; v2_r <= v2_nxt; kind_r <= kind_nxt; ires_r <= ires_nxt;
        last_r <= last_nxt; out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) res_r <= res_nxt;
  end

  assign out_tx_byte = res_r.tx_byte;
  assign out_tx_valid = res_r.tx_valid;
  assign out_chip_select = res_r.chip_select;
  assign out_resp_byte = res_r.resp_byte;
  assign out_done_res = res_r.done_res;
  assign out_init_status = res_r.init_status;
  assign out_card_type = res_r.card_type;
  assign out_high_capacity = res_r.high_capacity;

  a_no_tx_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_byte == 8'h00 && !out_chip_select)
    else $error("idle result drives a byte");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(acc) && out_done_res |-> phase_r == PH_IDLE && stage_r == ST_NONE)
    else $error("done without returning idle");
  a_frame_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FRAME |-> cnt_r <= 4'd5)
    else $error("frame byte count overflow");
endmodule
`default_nettype wire
